// File: hdl/rrh_pkg.sv
`default_nettype none

package rrh_pkg;

    // Default table depth
    localparam int REGIONS_DEF = 32;

    // Fixed field widths
    localparam int POS_W  = 16;
    localparam int SIZE_W = 15;
    localparam int TAG_W  = 8;
    localparam int SLOT_W = 5;
    localparam int EDGE_W = POS_W + 1;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_ADD   = 2'd1,
        KIND_QUERY = 2'd2
    } t_kind;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

    // Query token handed from cell to cell
    typedef struct packed {
        logic                     valid;
        logic                     found;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic [SLOT_W-1:0]        slot;
        logic [TAG_W-1:0]         tag;
    } t_token;

    // Slot write broadcast to all cells
    typedef struct packed {
        logic signed [POS_W-1:0]  left;
        logic signed [POS_W-1:0]  top;
        logic [SIZE_W-1:0]        wide;
        logic [SIZE_W-1:0]        tall;
        logic [TAG_W-1:0]         label;
    } t_region;

endpackage

`default_nettype wire

// File: hdl/rrh_cell.sv
`default_nettype none

module rrh_cell #(
    parameter int CNT_W = 6,
    parameter int INDEX = 0
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_wr_en,
    input  wire rrh_pkg::t_region   i_wr_data,
    input  wire rrh_pkg::t_token    i_tok,
    input  wire logic [CNT_W-1:0]   i_remain,
    output rrh_pkg::t_token         o_tok,
    output logic [CNT_W-1:0]        o_remain
);

    rrh_pkg::t_region r_region;
    rrh_pkg::t_token  r_tok;
    rrh_pkg::t_token  n_tok;
    logic [CNT_W-1:0] r_remain;
    logic [CNT_W-1:0] n_remain;

    logic signed [rrh_pkg::EDGE_W-1:0] w_px;
    logic signed [rrh_pkg::EDGE_W-1:0] w_py;
    logic signed [rrh_pkg::EDGE_W-1:0] w_left;
    logic signed [rrh_pkg::EDGE_W-1:0] w_top;
    logic signed [rrh_pkg::EDGE_W-1:0] w_right;
    logic signed [rrh_pkg::EDGE_W-1:0] w_bottom;
    logic                              w_live;
    logic                              w_inside;

    // Hold the rectangle of this slot
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_region <= i_wr_data;
        end
    end

    always_comb begin
        w_px     = {i_tok.pos_x[rrh_pkg::POS_W-1], i_tok.pos_x};
        w_py     = {i_tok.pos_y[rrh_pkg::POS_W-1], i_tok.pos_y};
        w_left   = {r_region.left[rrh_pkg::POS_W-1], r_region.left};
        w_top    = {r_region.top[rrh_pkg::POS_W-1], r_region.top};
        w_right  = w_left + $signed({2'b00, r_region.wide});
        w_bottom = w_top + $signed({2'b00, r_region.tall});
        w_live   = (i_remain != '0);
        w_inside = (w_px >= w_left) && (w_px < w_right) &&
                   (w_py >= w_top) && (w_py < w_bottom);

        n_tok    = i_tok;
        n_remain = w_live ? i_remain - CNT_W'(1) : i_remain;
        if (i_tok.valid && !i_tok.found && w_live && w_inside) begin
            n_tok.found = 1'b1;
            n_tok.slot  = rrh_pkg::SLOT_W'(INDEX);
            n_tok.tag   = r_region.label;
        end
    end

    // Advance the token one cell per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_remain <= n_remain;
    end

    assign o_tok    = r_tok;
    assign o_remain = r_remain;

endmodule

`default_nettype wire

// File: hdl/rect_region_hit_table.sv
// Channel | Direction | Handshake          | Word
// input   | in        | i_valid / o_ready  | i_kind, i_pos_x, i_pos_y, i_rect_width,
//         |           |                    | i_rect_height, i_entry_tag
// result  | out       | o_valid / i_ready  | o_hit, o_hit_slot, o_hit_tag, o_add_dropped
//
// Clear and add finish at the accept edge; their result word is valid the next cycle.
// A query walks a token down the row of REGIONS cells, one cell per cycle; its result
// word is registered once the token leaves the last cell.
// One word is in flight at a time; a new word is taken once the result slot is free
// or is being taken in the same cycle.
// Reset (synchronous, active low) empties the table and clears all valid flags.
// A stalled result holds its word until i_ready is seen.
`default_nettype none

module rect_region_hit_table #(
    parameter int REGIONS = rrh_pkg::REGIONS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [1:0]                         i_kind,
    input  wire logic signed [rrh_pkg::POS_W-1:0]   i_pos_x,
    input  wire logic signed [rrh_pkg::POS_W-1:0]   i_pos_y,
    input  wire logic [rrh_pkg::SIZE_W-1:0]         i_rect_width,
    input  wire logic [rrh_pkg::SIZE_W-1:0]         i_rect_height,
    input  wire logic [rrh_pkg::TAG_W-1:0]          i_entry_tag,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic                                    o_hit,
    output logic [rrh_pkg::SLOT_W-1:0]              o_hit_slot,
    output logic [rrh_pkg::TAG_W-1:0]               o_hit_tag,
    output logic                                    o_add_dropped
);

    localparam int CNT_W = $clog2(REGIONS + 1);

    rrh_pkg::t_state  r_state;
    rrh_pkg::t_state  n_state;
    rrh_pkg::t_kind   w_kind;
    logic [CNT_W-1:0] r_count;
    logic             w_accept;
    logic             w_full;
    logic             w_add;
    rrh_pkg::t_region w_wr_data;

    // Token and remaining-slot count between cells; entry 0 is the injection point
    rrh_pkg::t_token  w_tok    [0:REGIONS];
    logic [CNT_W-1:0] w_remain [0:REGIONS];

    // Result register
    logic                       r_out_valid;
    logic                       r_hit;
    logic [rrh_pkg::SLOT_W-1:0] r_hit_slot;
    logic [rrh_pkg::TAG_W-1:0]  r_hit_tag;
    logic                       r_add_dropped;

    assign w_kind   = rrh_pkg::t_kind'(i_kind);
    assign o_ready  = (r_state == rrh_pkg::ST_IDLE) && (!r_out_valid || i_ready);
    assign w_accept = i_valid && o_ready;
    assign w_full   = (r_count == CNT_W'(REGIONS));
    assign w_add    = w_accept && (w_kind == rrh_pkg::KIND_ADD) && !w_full;

    assign w_wr_data.left  = i_pos_x;
    assign w_wr_data.top   = i_pos_y;
    assign w_wr_data.wide  = i_rect_width;
    assign w_wr_data.tall  = i_rect_height;
    assign w_wr_data.label = i_entry_tag;

    // Inject a query token at the head of the row
    always_comb begin
        w_tok[0]       = '0;
        w_tok[0].valid = w_accept && (w_kind == rrh_pkg::KIND_QUERY);
        w_tok[0].pos_x = i_pos_x;
        w_tok[0].pos_y = i_pos_y;
        w_remain[0]    = r_count;
    end

    // One cell per slot; a cell is written when the fill count points at it
    for (genvar g = 0; g < REGIONS; g++) begin : g_cell
        rrh_cell #(
            .CNT_W (CNT_W),
            .INDEX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_en   (w_add && (r_count == CNT_W'(g))),
            .i_wr_data (w_wr_data),
            .i_tok     (w_tok[g]),
            .i_remain  (w_remain[g]),
            .o_tok     (w_tok[g+1]),
            .o_remain  (w_remain[g+1])
        );
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept && (w_kind == rrh_pkg::KIND_CLEAR)) begin
            r_count <= '0;
        end else if (w_add) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrh_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Stay in scan until the token leaves the last cell
    always_comb begin
        n_state = r_state;
        case (r_state)
            rrh_pkg::ST_IDLE: begin
                if (w_tok[0].valid) begin
                    n_state = rrh_pkg::ST_SCAN;
                end
            end
            rrh_pkg::ST_SCAN: begin
                if (w_tok[REGIONS].valid) begin
                    n_state = rrh_pkg::ST_IDLE;
                end
            end
            default: n_state = rrh_pkg::ST_IDLE;
        endcase
    end

    // Result valid flag: load on a finished word, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_accept && (w_kind != rrh_pkg::KIND_QUERY)) ||
                     w_tok[REGIONS].valid) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_tok[REGIONS].valid) begin
            r_hit         <= w_tok[REGIONS].found;
            r_hit_slot    <= w_tok[REGIONS].found ? w_tok[REGIONS].slot : '0;
            r_hit_tag     <= w_tok[REGIONS].found ? w_tok[REGIONS].tag : '0;
            r_add_dropped <= 1'b0;
        end else if (w_accept && (w_kind != rrh_pkg::KIND_QUERY)) begin
            r_hit         <= 1'b0;
            r_hit_slot    <= '0;
            r_hit_tag     <= '0;
            r_add_dropped <= (w_kind == rrh_pkg::KIND_ADD) && w_full;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_hit         = r_hit;
    assign o_hit_slot    = r_hit_slot;
    assign o_hit_tag     = r_hit_tag;
    assign o_add_dropped = r_add_dropped;

endmodule

`default_nettype wire

// File: hdl/rrh_checker.sv
`default_nettype none

module rrh_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic                       o_ready,
    input  wire logic [1:0]                 i_kind,
    input  wire logic                       o_valid,
    input  wire logic                       i_ready,
    input  wire logic                       o_hit,
    input  wire logic [rrh_pkg::SLOT_W-1:0] o_hit_slot,
    input  wire logic [rrh_pkg::TAG_W-1:0]  o_hit_tag,
    input  wire logic                       o_add_dropped
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_hit) &&
            $stable(o_hit_slot) && $stable(o_hit_tag) && $stable(o_add_dropped)))
        else $error("result word changed while stalled");

    // A miss reports slot and tag as zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> ((o_hit_slot == '0) && (o_hit_tag == '0)))
        else $error("miss with nonzero slot or tag");

    // A dropped add never reports a hit
    a_drop_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_add_dropped) |-> !o_hit)
        else $error("dropped add reported a hit");

    // Take a word only when the result slot is free or draining
    a_accept_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |-> (!o_valid || i_ready))
        else $error("word taken while result slot blocked");

    // Clear and add answer in the next cycle
    a_fast_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_kind != rrh_pkg::KIND_QUERY)) |=> o_valid)
        else $error("clear or add did not answer in one cycle");

endmodule

bind rect_region_hit_table rrh_checker u_rrh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_kind        (i_kind),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_hit         (o_hit),
    .o_hit_slot    (o_hit_slot),
    .o_hit_tag     (o_hit_tag),
    .o_add_dropped (o_add_dropped)
);

`default_nettype wire
